[rtl/pss_pkg.sv]
package pss_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned FOUND_W     = 7;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned CAPACITY_DF = 64;

  localparam logic [FOUND_W-1:0] NOT_FOUND = '1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_FIND   = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic    ins_en;
    logic    rem_en;
    action_e act;
  } ctrl_t;

  // lookup wave handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [DATA_W-1:0]   data;
    logic [FOUND_W-1:0]  idx;
  } carry_t;

endpackage

[rtl/pss_cell.sv]
module pss_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CMP_W = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pss_pkg::ctrl_t              ctrl_i,
  input  logic [CMP_W-1:0]            pos_i,
  input  logic [CMP_W-1:0]            count_i,
  input  logic [pss_pkg::DATA_W-1:0]  value_i,
  input  logic [pss_pkg::DATA_W-1:0]  left_i,
  input  logic [pss_pkg::DATA_W-1:0]  right_i,
  output logic [pss_pkg::DATA_W-1:0]  entry_o,
  input  pss_pkg::carry_t             carry_i,
  output pss_pkg::carry_t             carry_o
);
  import pss_pkg::*;

  localparam logic [CMP_W-1:0]   IDX_C = CMP_W'(INDEX);
  localparam logic [FOUND_W-1:0] IDX_F = FOUND_W'(INDEX);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              valid_q;
  logic              hit_q, hit_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [FOUND_W-1:0] idx_q, idx_d;
  logic              match;

  // entry shifting
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (IDX_C > pos_i) begin
        entry_d = left_i;
      end else if (IDX_C == pos_i) begin
        entry_d = value_i;
      end
    end else if (ctrl_i.rem_en) begin
      if (IDX_C >= pos_i) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // lookup wave: first matching cell claims it
  always_comb begin
    if (ctrl_i.act == ACT_FIND) begin
      match = (IDX_C < count_i) && (entry_q == value_i);
    end else begin
      match = (IDX_C == pos_i);
    end
    hit_d  = carry_i.hit;
    data_d = carry_i.data;
    idx_d  = carry_i.idx;
    if (!carry_i.hit && match) begin
      hit_d  = 1'b1;
      data_d = entry_q;
      idx_d  = IDX_F;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= carry_i.valid;
    end
  end

  // payload held once the wave has passed
  always_ff @(posedge clk_i) begin
    if (carry_i.valid) begin
      hit_q  <= hit_d;
      data_q <= data_d;
      idx_q  <= idx_d;
    end
  end

  assign entry_o       = entry_q;
  assign carry_o.valid = valid_q;
  assign carry_o.hit   = hit_q;
  assign carry_o.data  = data_q;
  assign carry_o.idx   = idx_q;

endmodule

[rtl/positional_sequence_store_unit.sv]
// Positional sequence store: an ordered list of up to CAPACITY signed 32-bit
// words held in a row of cells, one word per cell, plus a count. Each item is
// one action (insert, remove, read or find) and gives exactly one result item.
// Insert shifts every cell of the row together and writes its result from the
// exec state once the output register is free. Remove, read and find send a
// lookup wave down the row, one cell per cycle, so their result waits for the
// wave to leave the last cell and is then written from the finish state. Bad
// positions (and remove or read with nothing held) answer from the exec state
// with status out of range and send no wave. One item is worked on at
// a time; a new item is taken while the previous result still waits at the
// output, and then waits itself until the output register frees up.
module positional_sequence_store_unit #(
  parameter int unsigned CAPACITY = pss_pkg::CAPACITY_DF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         action_i,
  input  logic [pss_pkg::POS_W-1:0]          position_i,
  input  logic signed [pss_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pss_pkg::DATA_W-1:0]  value_out_o,
  output logic signed [pss_pkg::FOUND_W-1:0] found_index_o,
  output logic [pss_pkg::POS_W-1:0]          item_count_o,
  output logic [pss_pkg::STAT_W-1:0]         status_o
);
  import pss_pkg::*;

  // count must hold CAPACITY itself; compares run at the wider of count and
  // position widths
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  state_e state_q, state_d;

  // latched item
  action_e           act_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] value_q;

  logic [CNT_W-1:0]  count_q, count_d;

  // output register
  logic               out_valid_q;
  logic [DATA_W-1:0]  vout_q, vout_d;
  logic [FOUND_W-1:0] found_q, found_d;
  logic [POS_W-1:0]   ocnt_q;
  status_e            stat_q, stat_d;
  logic               out_we;
  logic               out_free;

  logic [CMP_W-1:0] pos_c, cnt_c;
  logic             start;
  ctrl_t            ctrl;

  logic [DATA_W-1:0] entry_w [CAPACITY];
  logic [DATA_W-1:0] left_w  [CAPACITY];
  logic [DATA_W-1:0] right_w [CAPACITY];
  carry_t            carry_w [CAPACITY+1];

  assign pos_c    = CMP_W'(pos_q);
  assign cnt_c    = CMP_W'(count_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    start       = 1'b0;
    ctrl.ins_en = 1'b0;
    ctrl.rem_en = 1'b0;
    ctrl.act    = act_q;
    out_we      = 1'b0;
    vout_d      = '0;
    found_d     = NOT_FOUND;
    stat_d      = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_q)
          ACT_INSERT: begin
            if (pos_c > cnt_c) begin
              stat_d = ST_RANGE;
            end else if (count_q == CAP_C) begin
              stat_d = ST_FULL;
            end
            if (out_free) begin
              out_we  = 1'b1;
              state_d = S_IDLE;
              if (stat_d == ST_OK) begin
                ctrl.ins_en = 1'b1;
                count_d     = count_q + 1'b1;
              end
            end
          end
          ACT_REMOVE, ACT_READ: begin
            if (pos_c >= cnt_c) begin
              stat_d = ST_RANGE;
              if (out_free) begin
                out_we  = 1'b1;
                state_d = S_IDLE;
              end
            end else begin
              start   = 1'b1;
              state_d = S_SCAN;
            end
          end
          default: begin
            start   = 1'b1;
            state_d = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        if (carry_w[CAPACITY].valid) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (act_q == ACT_FIND) begin
          found_d = carry_w[CAPACITY].hit ? carry_w[CAPACITY].idx : NOT_FOUND;
        end else begin
          vout_d = carry_w[CAPACITY].data;
        end
        if (out_free) begin
          out_we  = 1'b1;
          state_d = S_IDLE;
          if (act_q == ACT_REMOVE) begin
            ctrl.rem_en = 1'b1;
            count_d     = count_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q   <= action_e'(action_i);
      pos_q   <= position_i;
      value_q <= value_i;
    end
    if (out_we) begin
      vout_q  <= vout_d;
      found_q <= found_d;
      ocnt_q  <= POS_W'(count_d);
      stat_q  <= stat_d;
    end
  end

  // wave enters at cell 0 with nothing claimed
  assign carry_w[0].valid = start;
  assign carry_w[0].hit   = 1'b0;
  assign carry_w[0].data  = '0;
  assign carry_w[0].idx   = '0;

  // row of cells, each linked to its neighbours; value_q feeds cell 0
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_w[k] = value_q;
    end else begin : g_inner_l
      assign left_w[k] = entry_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w[k] = entry_w[k];
    end else begin : g_inner_r
      assign right_w[k] = entry_w[k+1];
    end

    pss_cell #(
      .INDEX (k),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (pos_c),
      .count_i (cnt_c),
      .value_i (value_q),
      .left_i  (left_w[k]),
      .right_i (right_w[k]),
      .entry_o (entry_w[k]),
      .carry_i (carry_w[k]),
      .carry_o (carry_w[k+1])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign value_out_o   = vout_q;
  assign found_index_o = found_q;
  assign item_count_o  = ocnt_q;
  assign status_o      = stat_q;

endmodule
